// ===== rtl/core/sidp_pkg.sv =====
// ----------------------------------------------------------------------------
// sidp_pkg
// shared constants and types for the stream id probe table
// ----------------------------------------------------------------------------
package sidp_pkg;

  localparam int TABLE_DEPTH      = 64;
  localparam int SLOT_BITS        = $clog2(TABLE_DEPTH);
  localparam int HANDLE_BITS      = 8;
  localparam int HANDLE_W         = 8;
  localparam int ID_W             = 64;
  localparam int ID_IDX_W         = $clog2(ID_W);
  localparam int SIZE_W           = 7;
  localparam int STATUS_W         = 2;
  localparam int SLOT_W           = 6;
  localparam int ENTRY_W          = ID_W + HANDLE_BITS;
  localparam int PADDR_W          = 3;
  localparam int PDATA_W          = 32;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(42);

  // remainder is built eight identifier bits per cycle
  localparam int DIV_CHUNK  = 8;
  localparam int DIV_STEPS  = ID_W / DIV_CHUNK;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // register index decode
  localparam logic REG_TABLE_SIZE = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2,
    ST_ZERO = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_INIT,
    S_REG,
    S_LRD,
    S_LCMP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    load;
    logic    mod_step;
    logic    probe_init;
    logic    probe_adv;
    logic    slot_write;
    logic    res_set;
    status_t res_code;
    logic    out_load;
  } sidp_cmd_t;

  typedef struct packed {
    logic size_zero;
    logic mode_lookup;
    logic mod_done;
    logic cur_valid;
    logic id_match;
    logic last_probe;
    logic out_busy;
  } sidp_stat_t;

endpackage

// ===== rtl/core/sidp_ram.sv =====
// ----------------------------------------------------------------------------
// sidp_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module sidp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sidp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sidp_ctrl
// sequencer for remainder, probe walk and result hand-off
// ----------------------------------------------------------------------------
module sidp_ctrl
  import sidp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  sidp_stat_t stat,
  output sidp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = stat.size_zero ? S_EMIT : S_DIV;
        end
      end
      S_DIV: begin
        if (stat.mod_done) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        state_next = stat.mode_lookup ? S_LRD : S_REG;
      end
      S_REG: begin
        if (!stat.cur_valid || stat.last_probe) begin
          state_next = S_EMIT;
        end
      end
      S_LRD: begin
        state_next = S_LCMP;
      end
      S_LCMP: begin
        if ((stat.cur_valid && stat.id_match) || stat.last_probe) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_LRD;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.res_code = ST_OK;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.size_zero) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_ZERO;
          end
        end
      end
      S_DIV: begin
        cmd.mod_step = 1'b1;
      end
      S_INIT: begin
        cmd.probe_init = 1'b1;
      end
      S_REG: begin
        if (!stat.cur_valid) begin
          cmd.slot_write = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_code   = ST_OK;
        end else if (stat.last_probe) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_FULL;
        end else begin
          cmd.probe_adv = 1'b1;
        end
      end
      S_LRD: begin
        cmd.res_code = ST_OK;
      end
      S_LCMP: begin
        if (stat.cur_valid && stat.id_match) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OK;
        end else if (stat.last_probe) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_MISS;
        end else begin
          cmd.probe_adv = 1'b1;
        end
      end
      S_EMIT: begin
        cmd.out_load = !stat.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/sidp_dp.sv =====
// ----------------------------------------------------------------------------
// sidp_dp
// item registers, remainder unit, probe pointer, slot store and result register
// ----------------------------------------------------------------------------
module sidp_dp
  import sidp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [SIZE_W-1:0]   table_size,
  input  logic                mode,
  input  logic [ID_W-1:0]     flow_id,
  input  logic [HANDLE_W-1:0] handle,
  input  sidp_cmd_t           cmd,
  output sidp_stat_t          stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot,
  output logic [HANDLE_W-1:0] found_handle
);

  logic [SIZE_W-1:0]      sz;
  logic                   mode_q;
  logic [ID_W-1:0]        id_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [SLOT_BITS-1:0]   rem_q;
  logic [SLOT_BITS-1:0]   rem_next;
  logic [SLOT_BITS-1:0]   pos_q;
  logic [SLOT_BITS-1:0]   pos_next;
  logic [SLOT_BITS-1:0]   count_q;
  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [ENTRY_W-1:0]     rd_entry;
  logic [STATUS_W-1:0]    res_status;
  logic [SLOT_W-1:0]      res_slot;
  logic [HANDLE_W-1:0]    res_handle;

  assign sz = (table_size > SIZE_W'(TABLE_DEPTH)) ? SIZE_W'(TABLE_DEPTH) : table_size;

  // one chunk of identifier bits, msb first, folded into the remainder
  always_comb begin
    logic [DIV_CHUNK-1:0]        chunk;
    logic [SLOT_BITS-1:0]        r;
    logic [SIZE_W-1:0]           t;
    logic [ID_IDX_W-1:0]         base;
    base  = ID_IDX_W'((DIV_STEPS - 1 - int'(div_cnt)) * DIV_CHUNK);
    chunk = id_q[base +: DIV_CHUNK];
    r     = rem_q;
    for (int k = DIV_CHUNK - 1; k >= 0; k--) begin
      t = {r, chunk[k]};
      if (t >= sz) begin
        t = t - sz;
      end
      r = SLOT_BITS'(t);
    end
    rem_next = r;
  end

  assign pos_next = ((SIZE_W'(pos_q) + SIZE_W'(1)) == sz) ? '0 : pos_q + SLOT_BITS'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q   <= mode;
      id_q     <= flow_id;
      handle_q <= HANDLE_BITS'(handle);
      rem_q    <= '0;
    end else if (cmd.mod_step) begin
      rem_q <= rem_next;
    end
    if (cmd.probe_init) begin
      pos_q   <= rem_q;
      count_q <= '0;
    end else if (cmd.probe_adv) begin
      pos_q   <= pos_next;
      count_q <= count_q + SLOT_BITS'(1);
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_code;
      res_slot   <= (cmd.res_code == ST_OK) ? SLOT_W'(pos_q) : '0;
      res_handle <= (cmd.res_code == ST_OK && mode_q) ?
                    HANDLE_W'(rd_entry[HANDLE_BITS-1:0]) : '0;
    end
    if (cmd.out_load) begin
      status       <= res_status;
      slot         <= res_slot;
      found_handle <= res_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt    <= '0;
      slot_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        div_cnt <= '0;
      end else if (cmd.mod_step) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      if (cmd.slot_write) begin
        slot_valid[pos_q] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  sidp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.slot_write),
    .waddr (pos_q),
    .wdata ({id_q, handle_q}),
    .raddr (pos_q),
    .rdata (rd_entry)
  );

  assign stat.size_zero   = (sz == '0);
  assign stat.mode_lookup = mode_q;
  assign stat.mod_done    = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign stat.cur_valid   = slot_valid[pos_q];
  assign stat.id_match    = (rd_entry[ENTRY_W-1:HANDLE_BITS] == id_q);
  assign stat.last_probe  = (SIZE_W'(count_q) == sz - SIZE_W'(1));
  assign stat.out_busy    = out_valid && !out_ready;

endmodule

// ===== rtl/core/stream_id_probe_table.sv =====
// ----------------------------------------------------------------------------
// stream_id_probe_table
// hashed stream id to channel handle table with linear probing
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready): mode 0 registers flow_id with handle
// at the first free slot from home slot flow_id mod table_size; mode 1
// looks it up over one full pass of the active slots.
// output channel (out_valid/out_ready): one transaction per input with
// status, slot and found_handle.
// apb port: register 0 is table_size (reset 42, values above 64 act as 64).
// sequence: the home slot is built 8 id bits per cycle, the probe pointer
// is set to it, then each register probe checks the slot valid bit and each
// lookup probe reads the slot memory then compares, and last the result is
// handed off; a zero table_size skips straight to hand-off with status zero.
// one item is in flight at a time;
// a new item is taken while the previous result waits in the output
// register, and a stalled receiver holds the block before hand-off.
// reset empties the table (all slots free) and restores table_size.
// ----------------------------------------------------------------------------
module stream_id_probe_table
  import sidp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic [ID_W-1:0]     flow_id,
  input  logic [HANDLE_W-1:0] handle,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot,
  output logic [HANDLE_W-1:0] found_handle
);

  logic [SIZE_W-1:0] table_size;
  logic              reg_index;
  sidp_cmd_t         cmd;
  sidp_stat_t        stat;

  assign pready    = 1'b1;
  assign reg_index = paddr[PADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RESET;
    end else if (psel && penable && pwrite && reg_index == REG_TABLE_SIZE) begin
      table_size <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_TABLE_SIZE: prdata = PDATA_W'(table_size);
      default:        prdata = '0;
    endcase
  end

  sidp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sidp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .table_size   (table_size),
    .mode         (mode),
    .flow_id      (flow_id),
    .handle       (handle),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .slot         (slot),
    .found_handle (found_handle)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> slot == '0 && found_handle == '0)
    else $error("nonzero slot or handle on failing status");

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result loaded while controller idle");
`endif

endmodule
